[src/hnd_pkg.sv]
`default_nettype none

package hnd_pkg;

    localparam int unsigned HeightW = 16;
    localparam int unsigned MagW    = 31;
    localparam int unsigned RootW   = 32;
    localparam int unsigned QuoW    = 17;
    localparam int unsigned SqW     = 64;

    localparam logic [15:0] ScaleReset = 16'd256;
    localparam logic [QuoW-1:0] FullOne = 17'd65536;

    typedef logic [MagW-1:0]  mag_t;
    typedef logic [RootW-1:0] root_t;
    typedef logic [QuoW-1:0]  quo_t;
    typedef logic [SqW-1:0]   sq_t;

    // item data that rides beside the arithmetic
    typedef struct packed {
        logic [HeightW-1:0] height;
        logic               xneg;
        logic               zneg;
        mag_t               xm;
        mag_t               ym;
        mag_t               zm;
    } side_t;

    // map a quotient and its sign to (n+1)/2 in Q0.16, saturated
    function automatic logic [15:0] encode(input quo_t q, input logic neg);
        logic [17:0] v;
        begin
            if (neg)
            begin
                v = ({1'b0, FullOne} - {1'b0, q}) >> 1;
            end
            else
            begin
                v = ({1'b0, FullOne} + {1'b0, q}) >> 1;
            end
            if (v > 18'd65535)
            begin
                v = 18'd65535;
            end
            encode = v[15:0];
        end
    endfunction

endpackage

`default_nettype wire

[src/hnd_front.sv]
`default_nettype none

module hnd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [15:0]          height_scale,
    input  wire logic [15:0]          center_height,
    input  wire logic [15:0]          up_left,
    input  wire logic [15:0]          up_right,
    input  wire logic [15:0]          down_left,
    input  wire logic [15:0]          down_right,
    output logic                      out_valid,
    output hnd_pkg::sq_t              m,
    output hnd_pkg::side_t            side
);
    import hnd_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic [15:0]        h1_reg, h2_reg, h3_reg;
    logic signed [17:0] dx1_reg, dz1_reg;
    logic signed [34:0] xs2_reg, zs2_reg;
    logic               xn3_reg, zn3_reg;
    logic [33:0]        xm3_reg, zm3_reg;
    side_t              side4_reg, side5_reg, side6_reg;
    logic [61:0]        xsq5_reg, ysq5_reg, zsq5_reg;
    sq_t                m6_reg;

    logic signed [17:0] ul, ur, dl, dr;
    logic signed [17:0] dx1_next, dz1_next;
    logic signed [34:0] xs2_next, zs2_next;
    logic signed [34:0] xneg_v, zneg_v;
    logic [33:0]        orv;
    logic [1:0]         k;
    logic [33:0]        xsh, zsh;
    side_t              side4_next;

    always_comb
    begin
        ul = {{2{up_left[15]}}, up_left};
        ur = {{2{up_right[15]}}, up_right};
        dl = {{2{down_left[15]}}, down_left};
        dr = {{2{down_right[15]}}, down_right};
        dx1_next = (ul + dl) - (ur + dr);
        dz1_next = (ul + ur) - (dl + dr);
    end

    always_comb
    begin
        xs2_next = $signed({1'b0, height_scale}) * dx1_reg;
        zs2_next = $signed({1'b0, height_scale}) * dz1_reg;
        xneg_v   = -xs2_reg;
        zneg_v   = -zs2_reg;
    end

    // smallest shift that brings both magnitudes below 2^31
    always_comb
    begin
        orv = xm3_reg | zm3_reg;
        if (orv[33])
        begin
            k = 2'd3;
        end
        else if (orv[32])
        begin
            k = 2'd2;
        end
        else if (orv[31])
        begin
            k = 2'd1;
        end
        else
        begin
            k = 2'd0;
        end
        xsh = xm3_reg >> k;
        zsh = zm3_reg >> k;
        side4_next.height = h3_reg;
        side4_next.xneg   = xn3_reg;
        side4_next.zneg   = zn3_reg;
        side4_next.xm     = xsh[MagW-1:0];
        side4_next.zm     = zsh[MagW-1:0];
        side4_next.ym     = mag_t'(31'd1 << 25) >> k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg    <= center_height;
            dx1_reg   <= dx1_next;
            dz1_reg   <= dz1_next;
            h2_reg    <= h1_reg;
            xs2_reg   <= xs2_next;
            zs2_reg   <= zs2_next;
            h3_reg    <= h2_reg;
            xn3_reg   <= xs2_reg[34];
            zn3_reg   <= zs2_reg[34];
            xm3_reg   <= xs2_reg[34] ? xneg_v[33:0] : xs2_reg[33:0];
            zm3_reg   <= zs2_reg[34] ? zneg_v[33:0] : zs2_reg[33:0];
            side4_reg <= side4_next;
            side5_reg <= side4_reg;
            xsq5_reg  <= side4_reg.xm * side4_reg.xm;
            ysq5_reg  <= side4_reg.ym * side4_reg.ym;
            zsq5_reg  <= side4_reg.zm * side4_reg.zm;
            side6_reg <= side5_reg;
            m6_reg    <= {2'b00, xsq5_reg} + {2'b00, ysq5_reg} + {2'b00, zsq5_reg};
        end
    end

    assign out_valid = v6_reg;
    assign m         = m6_reg;
    assign side      = side6_reg;

endmodule

`default_nettype wire

[src/hnd_isqrt.sv]
`default_nettype none

module hnd_isqrt (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire hnd_pkg::sq_t         m,
    input  wire hnd_pkg::side_t       in_side,
    output logic                      out_valid,
    output hnd_pkg::root_t            root,
    output hnd_pkg::side_t            out_side
);
    import hnd_pkg::*;

    localparam int unsigned Steps = RootW;

    logic        v_st    [0:Steps];
    side_t       side_st [0:Steps];
    sq_t         m_st    [0:Steps];
    logic [33:0] rem_st  [0:Steps];
    root_t       root_st [0:Steps];

    assign v_st[0]    = in_valid;
    assign side_st[0] = in_side;
    assign m_st[0]    = m;
    assign rem_st[0]  = '0;
    assign root_st[0] = '0;

    // one root bit per stage, two radicand bits consumed each step
    for (genvar i = 0; i < Steps; i++)
    begin : g_step
        logic        v_reg;
        side_t       side_reg;
        sq_t         m_reg;
        logic [33:0] rem_reg;
        root_t       root_reg;
        logic [34:0] rem_in;
        logic [34:0] trial;
        logic        take;
        logic [34:0] rem_next;
        root_t       root_next;

        always_comb
        begin
            rem_in    = {rem_st[i][32:0], m_st[i][SqW-1:SqW-2]};
            trial     = {1'b0, root_st[i], 2'b01};
            take      = rem_in >= trial;
            rem_next  = take ? rem_in - trial : rem_in;
            root_next = {root_st[i][RootW-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_st[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg <= side_st[i];
                m_reg    <= m_st[i] << 2;
                rem_reg  <= rem_next[33:0];
                root_reg <= root_next;
            end
        end

        assign v_st[i+1]    = v_reg;
        assign side_st[i+1] = side_reg;
        assign m_st[i+1]    = m_reg;
        assign rem_st[i+1]  = rem_reg;
        assign root_st[i+1] = root_reg;
    end

    assign out_valid = v_st[Steps];
    assign root      = root_st[Steps];
    assign out_side  = side_st[Steps];

endmodule

`default_nettype wire

[src/hnd_div.sv]
`default_nettype none

module hnd_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire hnd_pkg::root_t       root,
    input  wire hnd_pkg::side_t       in_side,
    output logic                      out_valid,
    output hnd_pkg::quo_t             qx,
    output hnd_pkg::quo_t             qy,
    output hnd_pkg::quo_t             qz,
    output hnd_pkg::side_t            out_side
);
    import hnd_pkg::*;

    localparam int unsigned Steps = QuoW;
    localparam int unsigned Lanes = 3;

    logic  v_st    [0:Steps];
    side_t side_st [0:Steps];
    root_t r_st    [0:Steps];
    root_t rem_st  [0:Steps][0:Lanes-1];
    quo_t  q_st    [0:Steps][0:Lanes-1];

    assign v_st[0]      = in_valid;
    assign side_st[0]   = in_side;
    assign r_st[0]      = root;
    assign rem_st[0][0] = {1'b0, in_side.xm};
    assign rem_st[0][1] = {1'b0, in_side.ym};
    assign rem_st[0][2] = {1'b0, in_side.zm};
    assign q_st[0][0]   = '0;
    assign q_st[0][1]   = '0;
    assign q_st[0][2]   = '0;

    // restoring division of c * 2^16 by the root, one quotient bit per stage;
    // the first stage takes the integer bit without a shift
    for (genvar j = 0; j < Steps; j++)
    begin : g_step
        logic  v_reg;
        side_t side_reg;
        root_t r_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= v_st[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg <= side_st[j];
                r_reg    <= r_st[j];
            end
        end

        assign v_st[j+1]    = v_reg;
        assign side_st[j+1] = side_reg;
        assign r_st[j+1]    = r_reg;

        for (genvar l = 0; l < Lanes; l++)
        begin : g_lane
            root_t       rem_reg;
            quo_t        q_reg;
            logic [32:0] t;
            logic        ge;
            logic [32:0] rem_next;
            quo_t        q_next;

            always_comb
            begin
                if (j == 0)
                begin
                    t = {1'b0, rem_st[j][l]};
                end
                else
                begin
                    t = {rem_st[j][l], 1'b0};
                end
                ge       = t >= {1'b0, r_st[j]};
                rem_next = ge ? t - {1'b0, r_st[j]} : t;
                q_next   = {q_st[j][l][QuoW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= rem_next[RootW-1:0];
                    q_reg   <= q_next;
                end
            end

            assign rem_st[j+1][l] = rem_reg;
            assign q_st[j+1][l]   = q_reg;
        end
    end

    assign out_valid = v_st[Steps];
    assign qx        = q_st[Steps][0];
    assign qy        = q_st[Steps][1];
    assign qz        = q_st[Steps][2];
    assign out_side  = side_st[Steps];

endmodule

`default_nettype wire

[src/heightmap_normal_from_diagonals.sv]
// Surface normal of one heightmap cell from its four diagonal neighbors.
//
// Input stream (s_*): one word per cell, five signed Q1.15 heights. Output
// stream (m_*): one word per input word, in order: the center height and the
// three normal components mapped to (n+1)/2 in unsigned Q0.16.
// Config channel (cfg_*): writes height_scale (unsigned Q8.8); always ready.
// Write it only while no word is in flight.
//
// The pipeline has 56 register stages, which every accepted word passes
// through on its way from s_* to m_*. The stages are 6 front
// stages (sums, scale multiply, magnitude, normalizing shift, squares, sum),
// 32 square-root stages (one root bit each) and 17 divider stages (one
// quotient bit each, three lanes sharing the root), then the output register.
// Throughput is one word per cycle while the receiver does not stall.
//
// Reset clears every valid bit and loads height_scale with 1.0 (256).
// When the receiver stalls with a word in the output register the whole
// pipeline holds and s_tready drops in the same cycle; nothing is dropped
// or repeated.
`default_nettype none

module heightmap_normal_from_diagonals (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // center_height, up_left, up_right, down_left, down_right
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // height_out, normal_x, normal_y, normal_z
    output logic [63:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import hnd_pkg::*;

    logic        en;
    logic [15:0] scale_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;

    logic  fr_valid;
    sq_t   fr_m;
    side_t fr_side;
    logic  sq_valid;
    root_t sq_root;
    side_t sq_side;
    logic  dv_valid;
    quo_t  qx, qy, qz;
    side_t dv_side;

    // advance everything unless a finished word is waiting
    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= ScaleReset;
        end
        else if (cfg_valid)
        begin
            scale_reg <= cfg_data;
        end
    end

    hnd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .height_scale  (scale_reg),
        .center_height (s_tdata[15:0]),
        .up_left       (s_tdata[31:16]),
        .up_right      (s_tdata[47:32]),
        .down_left     (s_tdata[63:48]),
        .down_right    (s_tdata[79:64]),
        .out_valid     (fr_valid),
        .m             (fr_m),
        .side          (fr_side)
    );

    hnd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .m         (fr_m),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    hnd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .out_side  (dv_side)
    );

    always_comb
    begin
        out_data_next = {encode(qz, dv_side.zneg),
                         encode(qy, 1'b0),
                         encode(qx, dv_side.xneg),
                         dv_side.height};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[src/hnd_checker.sv]
`default_nettype none

module hnd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [79:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [15:0] cfg_data
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output word changed while stalled");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_ny_upper: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47])
        else $error("normal_y below one half");

endmodule

bind heightmap_normal_from_diagonals hnd_checker u_hnd_checker (.*);

`default_nettype wire

[test/heightmap_normal_from_diagonals_test.sv]
`default_nettype none

module heightmap_normal_from_diagonals_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hnd_pkg::*;

    localparam int unsigned PipeDepth  = 56;
    localparam int unsigned StallLimit = 20000;
    localparam logic [31:0] Limit31    = 32'h8000_0000;

    typedef struct packed {
        logic [15:0] down_right;
        logic [15:0] down_left;
        logic [15:0] up_right;
        logic [15:0] up_left;
        logic [15:0] center_height;
    } cell_t;

    typedef struct packed {
        logic [15:0] normal_z;
        logic [15:0] normal_y;
        logic [15:0] normal_x;
        logic [15:0] height_out;
    } texel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [15:0] scale_shadow;
    texel_t      expected_texels[$];
    int          error_count;
    int          cells_sent;
    int          texels_seen;
    int          idle_cycles;
    int          scales_used;
    bit          stall_enable;

    heightmap_normal_from_diagonals DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] root64(input logic [63:0] m);
        logic [63:0] r;
        logic [63:0] bitv;
        begin
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > m)
            begin
                bitv = bitv >> 2;
            end
            while (bitv != 0)
            begin
                if (m >= r + bitv)
                begin
                    m = m - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else
                begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            return r;
        end
    endfunction

    function automatic logic [15:0] map_component(input logic [63:0] mag, input bit neg,
                                                  input logic [63:0] r);
        logic [63:0] q;
        logic [63:0] v;
        begin
            q = (mag * 64'd65536) / r;
            if (q > 64'd65536)
            begin
                q = 64'd65536;
            end
            v = neg ? ((64'd65536 - q) >> 1) : ((64'd65536 + q) >> 1);
            if (v > 64'd65535)
            begin
                v = 64'd65535;
            end
            return v[15:0];
        end
    endfunction

    function automatic texel_t surface_normal(input cell_t c, input logic [15:0] scale);
        longint dx;
        longint dz;
        longint xs;
        longint zs;
        bit          xneg;
        bit          zneg;
        logic [63:0] xm;
        logic [63:0] zm;
        logic [63:0] ym;
        logic [63:0] r;
        int          k;
        texel_t      t;
        begin
            dx = (longint'($signed(c.up_left)) + longint'($signed(c.down_left)))
               - (longint'($signed(c.up_right)) + longint'($signed(c.down_right)));
            dz = (longint'($signed(c.up_left)) + longint'($signed(c.up_right)))
               - (longint'($signed(c.down_left)) + longint'($signed(c.down_right)));
            xs = longint'(scale) * dx;
            zs = longint'(scale) * dz;
            xneg = xs < 0;
            zneg = zs < 0;
            xm = xneg ? -xs : xs;
            zm = zneg ? -zs : zs;
            ym = 64'd1 << 25;
            k = 0;
            while (k < 7 && ((xm >> k) >= Limit31 || (zm >> k) >= Limit31))
            begin
                k++;
            end
            xm = xm >> k;
            zm = zm >> k;
            ym = ym >> k;
            r = root64(xm * xm + ym * ym + zm * zm);
            if (r == 0)
            begin
                r = 1;
            end
            t.height_out = c.center_height;
            t.normal_x = map_component(xm, xneg, r);
            t.normal_y = map_component(ym, 1'b0, r);
            t.normal_z = map_component(zm, zneg, r);
            return t;
        end
    endfunction

    // idle for a random gap: mostly short, now and then long
    task automatic random_gap();
        begin
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    // drive one word and hold until accepted
    task automatic send_cell(input cell_t c, input bit gaps);
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= c;
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            expected_texels.insert(expected_texels.size(), surface_normal(c, scale_shadow));
            cells_sent++;
            @(negedge clk);
            if (gaps && $urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                random_gap();
            end
        end
    endtask

    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            while (expected_texels.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (PipeDepth + 4) @(negedge clk);
        end
    endtask

    task automatic write_scale(input logic [15:0] value);
        begin
            drain();
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            scale_shadow = value;
            scales_used++;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic logic [15:0] random_height();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(($urandom_range(0, 63) ^ 32) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        begin
            c.center_height = 16'($urandom);
            c.up_left    = random_height();
            c.up_right   = random_height();
            c.down_left  = random_height();
            c.down_right = random_height();
            // flat patches leave the normal straight up
            if ($urandom_range(0, 15) == 0)
            begin
                c.up_right = c.up_left;
                c.down_left = c.up_left;
                c.down_right = c.up_left;
            end
            return c;
        end
    endfunction

    task automatic test_directed_extremes();
        logic [15:0] hi;
        logic [15:0] lo;
        begin
            hi = 16'h7fff;
            lo = 16'h8000;
            send_cell({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
            send_cell({hi, hi, hi, hi, hi}, 1'b0);
            send_cell({lo, lo, lo, lo, lo}, 1'b0);
            // steepest slopes along each axis and along one diagonal, plus twisted cells
            send_cell({lo, hi, lo, hi, 16'h1234}, 1'b0);
            send_cell({hi, lo, hi, lo, 16'hedcb}, 1'b0);
            send_cell({lo, lo, hi, hi, 16'h7fff}, 1'b0);
            send_cell({hi, hi, lo, lo, 16'h8000}, 1'b0);
            send_cell({lo, hi, hi, lo, 16'h0001}, 1'b0);
            send_cell({hi, lo, lo, hi, 16'hffff}, 1'b0);
            send_cell({lo, lo, lo, hi, 16'h5555}, 1'b0);
            send_cell({hi, hi, hi, lo, 16'haaaa}, 1'b0);
            send_cell({16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000}, 1'b0);
            send_cell({16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0);
        end
    endtask

    task automatic test_scale_sweep();
        logic [15:0] scales[6];
        begin
            scales = '{16'd0, 16'hffff, 16'd1, 16'h8000, 16'h7fff, 16'd256};
            foreach (scales[i])
            begin
                write_scale(scales[i]);
                test_directed_extremes();
            end
        end
    endtask

    task automatic test_random_cells(input int count);
        begin
            for (int phase = 0; phase < 6; phase++)
            begin
                write_scale(phase == 0 ? 16'd0 : phase == 1 ? 16'hffff : 16'($urandom));
                stall_enable = (phase != 3);
                for (int i = 0; i < count / 6; i++)
                begin
                    send_cell(random_cell(), phase != 2);
                end
            end
            stall_enable = 1'b1;
        end
    endtask

    // receiver: random stalls, with some stretches always ready
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (!stall_enable)
        begin
            m_tready <= 1'b1;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            m_tready <= $urandom_range(0, 7) == 0;
        end
        else
        begin
            m_tready <= $urandom_range(0, 5) != 0;
        end
    end

    always @(posedge clk)
    begin
        texel_t got;
        texel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            texels_seen++;
            if (expected_texels.size() == 0)
            begin
                $error("output word with nothing expected: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_texels.pop_front();
                if (got.height_out !== want.height_out)
                begin
                    $error("height_out expected %h actual %h", want.height_out, got.height_out);
                    error_count++;
                end
                if (got.normal_x !== want.normal_x)
                begin
                    $error("normal_x expected %0d actual %0d", want.normal_x, got.normal_x);
                    error_count++;
                end
                if (got.normal_y !== want.normal_y)
                begin
                    $error("normal_y expected %0d actual %0d", want.normal_y, got.normal_y);
                    error_count++;
                end
                if (got.normal_z !== want.normal_z)
                begin
                    $error("normal_z expected %0d actual %0d", want.normal_z, got.normal_z);
                    error_count++;
                end
            end
        end
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit)
            begin
                $display("watchdog: no handshake for %0d cycles", StallLimit);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_tready = 1'b0;
        stall_enable = 1'b1;
        scale_shadow = ScaleReset;
        error_count = 0;
        cells_sent = 0;
        texels_seen = 0;
        idle_cycles = 0;
        scales_used = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // reset scale of 1.0 first
        test_directed_extremes();
        test_scale_sweep();
        test_random_cells(1560);
        drain();
        $display("covered %0d cells and %0d output words over %0d scale settings",
                 cells_sent, texels_seen, scales_used);
        if (error_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
